// ===== sv/hrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrtp_pkg
// Types and constants shared by the RTP packetizer front end, queue and
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hrtp_pkg;

	localparam int unsigned PAYLOAD_BITS = 11;
	localparam int unsigned PT_BITS      = 7;
	localparam int unsigned SSRC_BITS    = 32;
	localparam int unsigned TS_BITS      = 32;
	localparam int unsigned SEQ_BITS     = 16;
	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PAYLOAD  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PAYLOAD_TYPE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_ID    = 2'd2;

	localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD_RESET = 11'd1400;
	localparam logic [PT_BITS-1:0]      PT_RESET          = 7'd96;
	localparam logic [SSRC_BITS-1:0]    SSRC_RESET        = 32'd1;
	localparam logic [PAYLOAD_BITS-1:0] MIN_PAYLOAD       = 11'd16;
	localparam logic [PAYLOAD_BITS-1:0] MAX_PAYLOAD       = 11'd1460;

	localparam logic [7:0] RTP_V2        = 8'h80;
	localparam logic [4:0] FU_A_TYPE     = 5'd28;

	// queue between front end and back end
	localparam int unsigned Q_DEPTH     = 4;
	localparam int unsigned Q_PTR_BITS  = 2;
	localparam int unsigned Q_CNT_BITS  = 3;

	// position of the payload word within an expanded command
	localparam logic [3:0] LAST_IDX_DATA   = 4'd0;
	localparam logic [3:0] LAST_IDX_SINGLE = 4'd12;
	localparam logic [3:0] LAST_IDX_FRAG   = 4'd14;

	typedef enum logic [1:0] {
		CMD_DATA   = 2'd0,   // payload byte only
		CMD_SINGLE = 2'd1,   // RTP header, then payload byte
		CMD_FRAG   = 2'd2    // RTP header, FU indicator, FU header, payload byte
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [7:0]          data;
		logic                plast;
		logic                marker;
		logic [SEQ_BITS-1:0] seq;
		logic [TS_BITS-1:0]  ts;
		logic [7:0]          fu_ind;
		logic [7:0]          fu_hdr;
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/hrtp_front.sv =====
// ----------------------------------------------------------------------------
// hrtp_front
// Accepts NAL bytes, tracks NAL/fragment position and sequence number, and
// turns each byte into one packet command (or none for a held NAL header).
// ----------------------------------------------------------------------------
`default_nettype none

module hrtp_front #(
	parameter int unsigned LENGTH_BITS = 20
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         nal_byte,
	input  wire logic [LENGTH_BITS-1:0]             nal_length,
	input  wire logic [hrtp_pkg::TS_BITS-1:0]       timestamp,
	input  wire logic [hrtp_pkg::PAYLOAD_BITS-1:0]  max_payload,
	input  wire logic                               q_full,
	output logic                                    push,
	output hrtp_pkg::cmd_t                          cmd
);

	logic [LENGTH_BITS-1:0]            pos_q;
	logic [hrtp_pkg::PAYLOAD_BITS-1:0] chunk_q;
	logic [LENGTH_BITS-1:0]            frag_idx_q;
	logic [7:0]                        held_q;
	logic                              mode_q;
	logic [hrtp_pkg::SEQ_BITS-1:0]     seq_q;

	logic [hrtp_pkg::PAYLOAD_BITS-1:0] mp;
	logic                              first;
	logic                              mode;
	logic [7:0]                        held;
	logic [LENGTH_BITS:0]              pos_inc;
	logic                              nal_end;
	logic                              last_frag;
	logic [hrtp_pkg::PAYLOAD_BITS:0]   chunk_inc;
	logic                              chunk_full;
	logic                              accept;
	logic                              emit;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		priority if (max_payload < hrtp_pkg::MIN_PAYLOAD) begin
			mp = hrtp_pkg::MIN_PAYLOAD;
		end else if (max_payload > hrtp_pkg::MAX_PAYLOAD) begin
			mp = hrtp_pkg::MAX_PAYLOAD;
		end else begin
			mp = max_payload;
		end
	end

	assign first      = (pos_q == '0);
	assign mode       = first ? (nal_length > LENGTH_BITS'(mp)) : mode_q;
	assign held       = (first && mode) ? nal_byte : held_q;
	assign pos_inc    = {1'b0, pos_q} + (LENGTH_BITS+1)'(1);
	assign nal_end    = pos_inc >= {1'b0, nal_length};
	assign last_frag  = {1'b0, nal_length} <= ({1'b0, pos_q} + (LENGTH_BITS+1)'(mp));
	assign chunk_inc  = {1'b0, chunk_q} + (hrtp_pkg::PAYLOAD_BITS+1)'(1);
	assign chunk_full = nal_end || (chunk_inc >= {1'b0, mp});

	always_comb begin
		emit        = 1'b0;
		cmd.kind    = hrtp_pkg::CMD_DATA;
		cmd.data    = nal_byte;
		cmd.plast   = nal_end;
		cmd.marker  = 1'b1;
		cmd.seq     = seq_q;
		cmd.ts      = timestamp;
		cmd.fu_ind  = {held[7:5], hrtp_pkg::FU_A_TYPE};
		cmd.fu_hdr  = {(frag_idx_q == '0), last_frag, 1'b0, held[4:0]};
		if (!mode) begin
			emit     = 1'b1;
			cmd.kind = first ? hrtp_pkg::CMD_SINGLE : hrtp_pkg::CMD_DATA;
		end else if (!first) begin
			emit       = 1'b1;
			cmd.kind   = (chunk_q == '0) ? hrtp_pkg::CMD_FRAG : hrtp_pkg::CMD_DATA;
			cmd.plast  = chunk_full;
			cmd.marker = last_frag;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			chunk_q    <= '0;
			frag_idx_q <= '0;
			held_q     <= '0;
			mode_q     <= 1'b0;
			seq_q      <= '0;
		end else if (accept) begin
			held_q <= held;
			if (push && cmd.kind != hrtp_pkg::CMD_DATA) begin
				seq_q <= seq_q + hrtp_pkg::SEQ_BITS'(1);
			end
			if (nal_end) begin
				pos_q      <= '0;
				chunk_q    <= '0;
				frag_idx_q <= '0;
				mode_q     <= 1'b0;
			end else begin
				pos_q  <= pos_inc[LENGTH_BITS-1:0];
				mode_q <= mode;
				if (mode && !first) begin
					chunk_q <= chunk_full ? '0 : chunk_inc[hrtp_pkg::PAYLOAD_BITS-1:0];
					if (chunk_q == '0) begin
						frag_idx_q <= frag_idx_q + LENGTH_BITS'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hrtp_queue.sv =====
// ----------------------------------------------------------------------------
// hrtp_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hrtp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hrtp_pkg::cmd_t wr_cmd,
	input  wire logic           pop,
	output hrtp_pkg::cmd_t      rd_cmd,
	output logic                full,
	output logic                not_empty
);

	hrtp_pkg::cmd_t                    mem_q [hrtp_pkg::Q_DEPTH];
	logic [hrtp_pkg::Q_PTR_BITS-1:0]   wr_ptr_q;
	logic [hrtp_pkg::Q_PTR_BITS-1:0]   rd_ptr_q;
	logic [hrtp_pkg::Q_CNT_BITS-1:0]   count_q;

	assign full      = (count_q == hrtp_pkg::Q_CNT_BITS'(hrtp_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hrtp_pkg::Q_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hrtp_pkg::Q_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + hrtp_pkg::Q_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - hrtp_pkg::Q_CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/hrtp_back.sv =====
// ----------------------------------------------------------------------------
// hrtp_back
// Expands queued commands into RTP packet words: header, FU bytes and the
// payload byte, one word per cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hrtp_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              head_valid,
	input  wire hrtp_pkg::cmd_t                    head,
	output logic                                   pop,
	input  wire logic [hrtp_pkg::PT_BITS-1:0]      payload_type,
	input  wire logic [hrtp_pkg::SSRC_BITS-1:0]    source_id,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [7:0]                             out_byte,
	output logic                                   packet_first,
	output logic                                   packet_last,
	output logic                                   run_last
);

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       plast_q;
	logic       rlast_q;

	logic [3:0] last_idx;
	logic       at_last;
	logic       load;
	logic [7:0] byte_nxt;

	always_comb begin
		unique case (head.kind)
			hrtp_pkg::CMD_SINGLE: last_idx = hrtp_pkg::LAST_IDX_SINGLE;
			hrtp_pkg::CMD_FRAG:   last_idx = hrtp_pkg::LAST_IDX_FRAG;
			default:              last_idx = hrtp_pkg::LAST_IDX_DATA;
		endcase
	end

	assign at_last = (idx_q == last_idx);
	assign load    = head_valid && (!valid_q || out_ready);
	assign pop     = load && at_last;

	always_comb begin
		if (at_last) begin
			byte_nxt = head.data;
		end else begin
			unique case (idx_q)
				4'd0:    byte_nxt = hrtp_pkg::RTP_V2;
				4'd1:    byte_nxt = {head.marker, payload_type};
				4'd2:    byte_nxt = head.seq[15:8];
				4'd3:    byte_nxt = head.seq[7:0];
				4'd4:    byte_nxt = head.ts[31:24];
				4'd5:    byte_nxt = head.ts[23:16];
				4'd6:    byte_nxt = head.ts[15:8];
				4'd7:    byte_nxt = head.ts[7:0];
				4'd8:    byte_nxt = source_id[31:24];
				4'd9:    byte_nxt = source_id[23:16];
				4'd10:   byte_nxt = source_id[15:8];
				4'd11:   byte_nxt = source_id[7:0];
				4'd12:   byte_nxt = head.fu_ind;
				4'd13:   byte_nxt = head.fu_hdr;
				default: byte_nxt = head.data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= byte_nxt;
			first_q <= (idx_q == '0) && (head.kind != hrtp_pkg::CMD_DATA);
			plast_q <= at_last && head.plast;
			rlast_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? '0 : idx_q + 4'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign packet_first = first_q;
	assign packet_last  = plast_q;
	assign run_last     = rlast_q;

endmodule

`default_nettype wire

// ===== sv/h264_rtp_packetizer_unit.sv =====
// An accepted byte's command is queued, then registered by the back end onto
// m_*. Throughput: the back end's output stage gives one word per cycle unless
// m_tready stalls it; a payload byte is one word, a packet start is 13 words
// (single NAL) or 15 words (FU-A). Input takes a byte per cycle while the
// 4-entry command queue has room. Reset: position, sequence number and queue
// clear; max_payload=1400, payload_type=96, source_id=1.
// ----------------------------------------------------------------------------
// h264_rtp_packetizer_unit
// H.264 NAL byte stream to RTP packet byte stream, single NAL or FU-A.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_packetizer_unit #(
	parameter int unsigned LENGTH_BITS = 20
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// nal_byte, nal_length, timestamp (from bit 0), zero padded
	input  wire logic [((40+LENGTH_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// out_byte
	output logic [7:0]                                  m_tdata,
	// packet_first, run_last (from bit 0)
	output logic [1:0]                                  m_tuser,
	output logic                                        m_tlast,
	input  wire logic                                   wr_en,
	input  wire logic [hrtp_pkg::CFG_INDEX_BITS-1:0]    wr_index,
	input  wire logic [hrtp_pkg::CFG_DATA_BITS-1:0]     wr_data
);

	logic [hrtp_pkg::PAYLOAD_BITS-1:0] max_payload_q;
	logic [hrtp_pkg::PT_BITS-1:0]      payload_type_q;
	logic [hrtp_pkg::SSRC_BITS-1:0]    source_id_q;

	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;
	hrtp_pkg::cmd_t wr_cmd;
	hrtp_pkg::cmd_t rd_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q  <= hrtp_pkg::MAX_PAYLOAD_RESET;
			payload_type_q <= hrtp_pkg::PT_RESET;
			source_id_q    <= hrtp_pkg::SSRC_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				hrtp_pkg::REG_MAX_PAYLOAD:
					max_payload_q <= wr_data[hrtp_pkg::PAYLOAD_BITS-1:0];
				hrtp_pkg::REG_PAYLOAD_TYPE:
					payload_type_q <= wr_data[hrtp_pkg::PT_BITS-1:0];
				hrtp_pkg::REG_SOURCE_ID:
					source_id_q <= wr_data[hrtp_pkg::SSRC_BITS-1:0];
				default: ;
			endcase
		end
	end

	hrtp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.nal_byte    (s_tdata[7:0]),
		.nal_length  (s_tdata[8 +: LENGTH_BITS]),
		.timestamp   (s_tdata[8+LENGTH_BITS +: hrtp_pkg::TS_BITS]),
		.max_payload (max_payload_q),
		.q_full      (q_full),
		.push        (push),
		.cmd         (wr_cmd)
	);

	hrtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.rd_cmd    (rd_cmd),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	hrtp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_not_empty),
		.head         (rd_cmd),
		.pop          (pop),
		.payload_type (payload_type_q),
		.source_id    (source_id_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.packet_first (m_tuser[0]),
		.packet_last  (m_tlast),
		.run_last     (m_tuser[1])
	);

endmodule

`default_nettype wire
